// File: rtl/gscf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gscf_pkg
// Shared widths and defaults for the glyph slot cache.
// ----------------------------------------------------------------------------
package gscf_pkg;

    localparam int CODE_W       = 21;   // character code width
    localparam int SLOT_W       = 8;    // glyph slot number width
    localparam int S_TDATA_W    = 24;   // code_point padded to bytes
    localparam int M_TDATA_W    = 16;   // glyph_slot, fill_needed padded to bytes
    localparam int SLOT_SUM_W   = 10;   // room for base + index before masking

    localparam int DEF_ASCII_SLOTS   = 128;
    localparam int DEF_DYNAMIC_SLOTS = 32;

endpackage : gscf_pkg
`default_nettype wire

// File: rtl/gscf_tag_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gscf_tag_store
// Dynamic slot tag memory: one write port, one registered read port.
// Per-entry valid bits cleared at reset; an unwritten entry reads as zero.
// ----------------------------------------------------------------------------
module gscf_tag_store
    import gscf_pkg::*;
#(
    parameter int DEPTH  = DEF_DYNAMIC_SLOTS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [CODE_W-1:0] rd_tag,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [CODE_W-1:0] wr_tag
);

    logic [CODE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [CODE_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_tag;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_tag = rd_valid_reg ? rd_data_reg : '0;

endmodule : gscf_tag_store
`default_nettype wire

// File: rtl/glyph_slot_cache_fifo_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_slot_cache_fifo_top
// Maps a character code to a glyph store slot. Codes below ASCII_SLOTS use
// their own fixed slot; others are looked up among DYNAMIC_SLOTS tags with
// round-robin (oldest first) replacement on a miss.
// ----------------------------------------------------------------------------
//
//  channel  | dir | word fields (low bit up)             | handshake
//  ---------+-----+--------------------------------------+--------------------
//  s_axis   | in  | code_point[20:0], pad                | tvalid & tready
//  m_axis   | out | glyph_slot[7:0], fill_needed, pad    | tvalid & tready
//
// A fixed-slot code is accepted, then loaded into the output register. A
// dynamic code scans the tag memory one entry per cycle on its single read
// port: a miss reads every entry, a hit stops at the first matching one.
// s_axis_tready is high only in idle. A result waits in ST_OUT until the
// output register frees, so a held-off receiver stalls the input.
// Reset (aresetn low, synchronous) clears the tag valid bits and evict pointer.
// ----------------------------------------------------------------------------
module glyph_slot_cache_fifo_top
    import gscf_pkg::*;
#(
    parameter int ASCII_SLOTS   = DEF_ASCII_SLOTS,
    parameter int DYNAMIC_SLOTS = DEF_DYNAMIC_SLOTS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // [20:0] code_point
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [M_TDATA_W-1:0] m_axis_tdata    // [7:0] glyph_slot, [8] fill_needed
);

    localparam int IDX_W = $clog2(DYNAMIC_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DYNAMIC_SLOTS - 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;        // read address being issued
    logic              issue_reg, issue_next;    // more entries to read
    logic [IDX_W-1:0]  cmp_idx_reg;              // entry whose tag is on rd_tag
    logic              cmp_live_reg;
    logic [IDX_W-1:0]  evict_reg, evict_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic              res_fill_reg, res_fill_next;
    logic              m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0] m_slot_reg, m_slot_next;
    logic              m_fill_reg, m_fill_next;

    logic              s_accept;
    logic              out_free;
    logic              rd_en;
    logic [CODE_W-1:0] rd_tag;
    logic              tag_hit;
    logic              tag_miss;
    logic              wr_en;
    logic [CODE_W-1:0] in_code;
    logic [SLOT_SUM_W-1:0] hit_sum;
    logic [SLOT_SUM_W-1:0] miss_sum;

    assign in_code       = s_axis_tdata[CODE_W-1:0];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign rd_en    = (state_reg == ST_SCAN) && issue_reg;
    assign tag_hit  = (state_reg == ST_SCAN) && cmp_live_reg && (rd_tag == code_reg);
    assign tag_miss = (state_reg == ST_SCAN) && cmp_live_reg && !tag_hit
                      && (cmp_idx_reg == LAST_IDX);
    assign wr_en    = tag_miss;

    // slot = base + index, kept to the low 8 bits
    assign hit_sum  = SLOT_SUM_W'(ASCII_SLOTS) + SLOT_SUM_W'(cmp_idx_reg);
    assign miss_sum = SLOT_SUM_W'(ASCII_SLOTS) + SLOT_SUM_W'(evict_reg);

    gscf_tag_store #(
        .DEPTH  (DYNAMIC_SLOTS),
        .ADDR_W (IDX_W)
    ) u_tags (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_tag  (rd_tag),
        .wr_en   (wr_en),
        .wr_addr (evict_reg),
        .wr_tag  (code_reg)
    );

    always_comb begin
        state_next    = state_reg;
        code_next     = code_reg;
        idx_next      = idx_reg;
        issue_next    = issue_reg;
        evict_next    = evict_reg;
        res_slot_next = res_slot_reg;
        res_fill_next = res_fill_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_slot_next   = m_slot_reg;
        m_fill_next   = m_fill_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    code_next = in_code;
                    if (in_code < CODE_W'(ASCII_SLOTS)) begin
                        // fixed slot: the code is the slot number
                        res_slot_next = in_code[SLOT_W-1:0];
                        res_fill_next = 1'b0;
                        state_next    = ST_OUT;
                    end else begin
                        idx_next   = '0;
                        issue_next = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (issue_reg) begin
                    if (idx_reg == LAST_IDX) begin
                        issue_next = 1'b0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                if (tag_hit) begin
                    // first match in scan order is the lowest slot
                    res_slot_next = hit_sum[SLOT_W-1:0];
                    res_fill_next = 1'b0;
                    issue_next    = 1'b0;
                    state_next    = ST_OUT;
                end else if (tag_miss) begin
                    res_slot_next = miss_sum[SLOT_W-1:0];
                    res_fill_next = 1'b1;
                    evict_next    = (evict_reg == LAST_IDX) ? '0 : evict_reg + 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_slot_next  = res_slot_reg;
                    m_fill_next  = res_fill_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            issue_reg    <= 1'b0;
            cmp_live_reg <= 1'b0;
            evict_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            issue_reg    <= issue_next;
            cmp_live_reg <= rd_en;
            evict_reg    <= evict_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        code_reg     <= code_next;
        idx_reg      <= idx_next;
        cmp_idx_reg  <= idx_reg;
        res_slot_reg <= res_slot_next;
        res_fill_reg <= res_fill_next;
        m_slot_reg   <= m_slot_next;
        m_fill_reg   <= m_fill_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - SLOT_W - 1){1'b0}}, m_fill_reg, m_slot_reg};

`ifndef NO_ASSERTIONS
    // a tag is only rewritten at the end of a full scan
    a_wr_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ST_SCAN) && (cmp_idx_reg == LAST_IDX))
        else $error("tag write outside end of scan");

    // every miss moves the evict pointer
    a_evict_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> evict_reg != $past(evict_reg))
        else $error("evict pointer did not advance on miss");

    // pointer only moves on a miss
    a_evict_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !wr_en |=> $stable(evict_reg))
        else $error("evict pointer moved without a miss");

    // an accepted code always leaves idle
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_axis_tready)
        else $error("ready after accept");

    // the output stage is left only for idle
    a_out_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |=> (state_reg == ST_OUT) || (state_reg == ST_IDLE))
        else $error("bad exit from output state");
`endif

endmodule : glyph_slot_cache_fifo_top
`default_nettype wire
